>>> design/mmdws_pkg.sv
// ----------------------------------------------------------------------------
// mmdws_pkg
// Shared types, mode codes and element kinds for the DMA write sequencer.
// ----------------------------------------------------------------------------
package mmdws_pkg;

	localparam int ADDR_BITS = 32;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [15:0]          word_t;
	typedef logic [2:0]           kind_t;
	typedef logic [2:0]           reg_idx_t;

	// configuration register indexes
	localparam reg_idx_t REG_MODE   = 3'd0;
	localparam reg_idx_t REG_FIRST  = 3'd1;
	localparam reg_idx_t REG_SECOND = 3'd2;
	localparam reg_idx_t REG_FILL   = 3'd3;
	localparam reg_idx_t REG_COUNT  = 3'd4;

	// mode codes
	localparam word_t MODE_SELF  = 16'hcffd;
	localparam word_t MODE_SWAP  = 16'he2dd;
	localparam word_t MODE_BUF   = 16'hfc2d;
	localparam word_t MODE_COPYA = 16'hfe3d;
	localparam word_t MODE_COPYB = 16'hfe6d;
	localparam word_t MODE_HALF  = 16'hfef5;
	localparam word_t MODE_BYTE  = 16'hffc5;
	localparam word_t MODE_FILLA = 16'hffcd;
	localparam word_t MODE_FILLB = 16'hffdd;

	// element kinds
	localparam kind_t K_NONE = 3'd0;
	localparam kind_t K_SELF = 3'd1;
	localparam kind_t K_SWAP = 3'd2;
	localparam kind_t K_BUF  = 3'd3;
	localparam kind_t K_COPY = 3'd4;
	localparam kind_t K_HALF = 3'd5;
	localparam kind_t K_BYTE = 3'd6;
	localparam kind_t K_FILL = 3'd7;

	function automatic kind_t mode_kind(input word_t mode);
		kind_t k;
		k = K_NONE;
		unique case (mode)
			MODE_SELF:              k = K_SELF;
			MODE_SWAP:              k = K_SWAP;
			MODE_BUF:               k = K_BUF;
			MODE_COPYA, MODE_COPYB: k = K_COPY;
			MODE_HALF:              k = K_HALF;
			MODE_BYTE:              k = K_BYTE;
			MODE_FILLA, MODE_FILLB: k = K_FILL;
			default:                k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

>>> design/multi_mode_dma_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// multi_mode_dma_write_sequencer_unit
// Register-programmed DMA engine: start and step beats in, bus writes out.
// ----------------------------------------------------------------------------
// The first result is registered in the result register, after the element register.
// One result per cycle while result_stall is low; an element yields 1 to 4 results,
//   one per beat (self-address mode 4, swap/buffer/half/byte modes 2, others 1).
// The element register accepts the next beat in the cycle its last write leaves.
// Reset (arst_n low, asynchronous): configuration, running state and valid flags clear, idle.
module multi_mode_dma_write_sequencer_unit
	import mmdws_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        cmd,
	input  logic [15:0] source_word,
	input  logic        source_ready,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        write_enable,
	output logic [31:0] write_address,
	output logic [15:0] write_data,
	output logic        upper_lane,
	output logic        lower_lane,
	output logic        last,
	output logic        finished,
	output logic [31:0] next_read_address
);

	// configuration registers
	word_t       mode_q;
	addr_t       first_q, second_q;
	word_t       fill_q;
	logic [31:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			first_q  <= '0;
			second_q <= '0;
			fill_q   <= '0;
			count_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[15:0];
				REG_FIRST:  first_q  <= cfg_data[ADDR_BITS-1:0];
				REG_SECOND: second_q <= cfg_data[ADDR_BITS-1:0];
				REG_FILL:   fill_q   <= cfg_data[15:0];
				REG_COUNT:  count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// running state
	addr_t       run_a_q, run_b_q;
	logic [31:0] left_q;
	logic        busy_q;

	// element register
	logic        valid_s1;
	kind_t       kind_s1;
	addr_t       a_s1, b_s1, nra_s1;
	word_t       src_s1;
	logic        fin_s1;
	logic [1:0]  beat_s1, last_beat_s1;

	logic accept, out_load, s1_done;

	assign out_load   = valid_s1 && (!result_valid || !result_stall);
	assign s1_done    = out_load && (beat_s1 == last_beat_s1);
	assign item_stall = valid_s1 && !s1_done;
	assign accept     = item_valid && !item_stall;

	// decode of the accepted beat against the current state
	kind_t       kind_c, kind_n;
	logic [1:0]  nlast_c;
	addr_t       inc_a, inc_b;
	logic        start_busy;

	always_comb begin
		kind_c = mode_kind(mode_q);
		inc_a  = '0;
		inc_b  = '0;
		nlast_c = 2'd0;
		case (kind_c)
			K_SELF: begin inc_a = addr_t'(8); nlast_c = 2'd3; end
			K_SWAP: begin inc_a = addr_t'(2); inc_b = addr_t'(4); nlast_c = 2'd1; end
			K_BUF:  begin inc_a = addr_t'(4); nlast_c = 2'd1; end
			K_COPY: begin inc_a = addr_t'(2); inc_b = addr_t'(2); end
			K_HALF: begin inc_a = addr_t'(4); nlast_c = 2'd1; end
			K_BYTE: begin inc_a = addr_t'(2); nlast_c = 2'd1; end
			K_FILL: inc_a = addr_t'(2);
			default: ;
		endcase
		start_busy = (kind_c != K_NONE) && (count_q != 32'd0)
			&& !((kind_c == K_BUF || kind_c == K_BYTE) && !source_ready);
		kind_n = (cmd && busy_q) ? kind_c : K_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_a_q <= '0;
			run_b_q <= '0;
			left_q  <= '0;
			busy_q  <= 1'b0;
		end else if (accept) begin
			if (!cmd) begin
				run_a_q <= first_q;
				run_b_q <= second_q;
				left_q  <= count_q;
				busy_q  <= start_busy;
			end else if (kind_n == K_NONE) begin
				busy_q <= 1'b0;
			end else begin
				run_a_q <= run_a_q + inc_a;
				run_b_q <= run_b_q + inc_b;
				left_q  <= left_q - 32'd1;
				busy_q  <= (left_q != 32'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_s1  <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			beat_s1  <= '0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (out_load) begin
			beat_s1 <= beat_s1 + 2'd1;
		end
	end

	// payload of the element register
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= kind_n;
			a_s1         <= run_a_q;
			b_s1         <= run_b_q;
			src_s1       <= (kind_n == K_FILL) ? fill_q : source_word;
			last_beat_s1 <= (kind_n == K_NONE) ? 2'd0 : nlast_c;
			if (!cmd) begin
				fin_s1 <= !start_busy;
				nra_s1 <= first_q;
			end else if (kind_n == K_NONE) begin
				fin_s1 <= 1'b1;
				nra_s1 <= run_a_q;
			end else begin
				fin_s1 <= (left_q == 32'd1);
				nra_s1 <= run_a_q + inc_a;
			end
		end
	end

	// one bus write per beat
	logic [31:0] a32;
	addr_t       base, offs, addr_c;
	word_t       data_c;
	logic        we_c, up_c, lo_c;
	logic [7:0]  byte_c;

	always_comb begin
		a32    = 32'(a_s1);
		base   = (kind_s1 == K_SWAP || kind_s1 == K_COPY) ? b_s1 : a_s1;
		offs   = (kind_s1 == K_BYTE) ? addr_t'(beat_s1) : addr_t'({beat_s1, 1'b0});
		addr_c = base + offs;
		byte_c = (beat_s1 == 2'd0) ? src_s1[15:8] : src_s1[7:0];
		we_c   = (kind_s1 != K_NONE);
		up_c   = we_c;
		lo_c   = we_c;
		data_c = '0;
		case (kind_s1)
			K_SELF: begin
				case (beat_s1)
					2'd0:    data_c = {8'd0, a32[31:24]};
					2'd1:    data_c = a32[31:16];
					2'd2:    data_c = a32[23:8];
					default: data_c = a32[15:0];
				endcase
			end
			K_SWAP: data_c = beat_s1[0] ? {src_s1[7:0], src_s1[15:8]} : src_s1;
			K_BUF:  data_c = beat_s1[0] ? src_s1 : {8'd0, src_s1[15:8]};
			K_HALF: data_c = beat_s1[0] ? a32[15:0] : a32[31:16];
			K_BYTE: begin
				// odd address goes on the lower lane
				if (addr_c[0]) begin
					data_c = {8'd0, byte_c};
					up_c   = 1'b0;
				end else begin
					data_c = {byte_c, 8'd0};
					lo_c   = 1'b0;
				end
			end
			K_COPY, K_FILL: data_c = src_s1;
			default: ;
		endcase
		if (!we_c) addr_c = '0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			write_enable      <= we_c;
			write_address     <= 32'(addr_c);
			write_data        <= data_c;
			upper_lane        <= up_c;
			lower_lane        <= lo_c;
			last              <= (beat_s1 == last_beat_s1);
			finished          <= fin_s1;
			next_read_address <= 32'(nra_s1);
		end
	end

`ifndef SYNTHESIS
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> beat_s1 <= last_beat_s1)
		else $error("beat index past last write of element");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!valid_s1 || s1_done))
		else $error("beat accepted while element still has writes pending");

	a_idle_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !write_enable) |-> (!upper_lane && !lower_lane && last))
		else $error("non-write result with lanes set or not last");

	a_multi_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && kind_s1 == K_NONE) |-> last_beat_s1 == 2'd0)
		else $error("non-write element with more than one result");
`endif

endmodule
